FILE: hdl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Shared widths, command, route, mapper and register codes of the mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int unsigned MAX_ROM_BANKS = 512;
    localparam int unsigned MAX_RAM_BYTES = 262144;

    localparam int unsigned CMD_W       = 2;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned ROUTE_W     = 3;
    localparam int unsigned PHYS_W      = 23;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned ROM_BANKS_W = 10;
    localparam int unsigned RAM_BYTES_W = 19;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 19;
    localparam int unsigned CLOCK_REGS  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [ROUTE_W-1:0] {
        ROUTE_OPEN_BUS  = 3'd0,
        ROUTE_ROM_READ  = 3'd1,
        ROUTE_RAM_READ  = 3'd2,
        ROUTE_RAM_WRITE = 3'd3,
        ROUTE_REG_DATA  = 3'd4,
        ROUTE_NONE      = 3'd5
    } t_route;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROM_ONLY   = 3'd0,
        KIND_FIVE_BIT   = 3'd1,
        KIND_NIBBLE_RAM = 3'd2,
        KIND_CLOCK      = 3'd3,
        KIND_WIDE_BANK  = 3'd4,
        KIND_SENSOR     = 3'd5
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAPPER_KIND = 2'd0,
        CFG_ROM_BANKS   = 2'd1,
        CFG_RAM_BYTES   = 2'd2
    } t_cfg_index;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0] SENSOR_BANK    = 8'h10;
    localparam logic [7:0] LATCH_RELEASE  = 8'h00;
    localparam logic [7:0] LATCH_CAPTURE  = 8'h01;

    function automatic logic [7:0] clock_mask(input logic [2:0] idx);
        logic [7:0] mask;
        case (idx)
            3'd0: begin
                mask = 8'h3F;
            end
            3'd1: begin
                mask = 8'h3F;
            end
            3'd2: begin
                mask = 8'h1F;
            end
            3'd3: begin
                mask = 8'hFF;
            end
            default: begin
                mask = 8'hC1;
            end
        endcase
        return mask;
    endfunction

endpackage

FILE: hdl/cbm_item_if.sv
// ----------------------------------------------------------------------------
// Bus item channel
// Carries one CPU bus access or clock tick per transfer.
// ----------------------------------------------------------------------------
interface cbm_item_if;
    logic                        valid;
    logic                        ready;
    logic [cbm_pkg::CMD_W-1:0]   cmd;
    logic [cbm_pkg::ADDR_W-1:0]  bus_address;
    logic [cbm_pkg::DATA_W-1:0]  bus_data;

    modport source (output valid, output cmd, output bus_address, output bus_data,
                    input ready);
    modport sink (input valid, input cmd, input bus_address, input bus_data,
                  output ready);
endinterface

FILE: hdl/cbm_result_if.sv
// ----------------------------------------------------------------------------
// Mapper result channel
// Carries the route, physical address and data of one decoded item.
// ----------------------------------------------------------------------------
interface cbm_result_if;
    logic                         valid;
    logic                         ready;
    logic [cbm_pkg::ROUTE_W-1:0]  route;
    logic [cbm_pkg::PHYS_W-1:0]   phys_address;
    logic [cbm_pkg::DATA_W-1:0]   out_data;
    logic                         force_high_nibble;

    modport source (output valid, output route, output phys_address, output out_data,
                    output force_high_nibble, input ready);
    modport sink (input valid, input route, input phys_address, input out_data,
                  input force_high_nibble, output ready);
endinterface

FILE: hdl/cartridge_bank_mapper_with_rtc.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper with clock
// Decodes CPU bus accesses by mapper kind, keeps banking and clock registers.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// i_item    in         cmd, bus_address, bus_data
// o_result  out        route, phys_address, out_data, force_high_nibble
// i_cfg_*   in         mapper_kind, rom_banks, ram_bytes (write only)
//
// One item per cycle while the result is taken; a result is offered from the
// result register, after the item has passed through the input register.
// Reset empties both stages and returns all mapper and clock registers.
// A stalled result holds; the input register still takes an item if it is empty.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_rtc #(
    parameter int unsigned MAX_ROM_BANKS = cbm_pkg::MAX_ROM_BANKS,
    parameter int unsigned MAX_RAM_BYTES = cbm_pkg::MAX_RAM_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    cbm_item_if.sink                            i_item,
    cbm_result_if.source                        o_result
);

    localparam logic [cbm_pkg::ROM_BANKS_W-1:0] ROM_CAP =
        cbm_pkg::ROM_BANKS_W'(MAX_ROM_BANKS);
    localparam logic [cbm_pkg::RAM_BYTES_W-1:0] RAM_CAP =
        cbm_pkg::RAM_BYTES_W'(MAX_RAM_BYTES);

    logic [cbm_pkg::KIND_W-1:0]       r_mapper_kind;
    logic [cbm_pkg::ROM_BANKS_W-1:0]  r_rom_banks;
    logic [cbm_pkg::RAM_BYTES_W-1:0]  r_ram_bytes;

    logic                             r_in_valid;
    logic [cbm_pkg::CMD_W-1:0]        r_in_cmd;
    logic [cbm_pkg::ADDR_W-1:0]       r_in_addr;
    logic [cbm_pkg::DATA_W-1:0]       r_in_data;

    logic                             r_out_valid;
    cbm_pkg::t_route                  r_out_route;
    logic [cbm_pkg::PHYS_W-1:0]       r_out_phys;
    logic [cbm_pkg::DATA_W-1:0]       r_out_data;
    logic                             r_out_force_high;

    logic [7:0]                       r_rom_bank_low;
    logic                             r_rom_bank_ninth;
    logic [7:0]                       r_ram_bank_select;
    logic                             r_ram_enable;
    logic                             r_banking_mode;
    logic [7:0]                       r_clock_live [cbm_pkg::CLOCK_REGS];
    logic [7:0]                       r_clock_snapshot [cbm_pkg::CLOCK_REGS];
    logic                             r_clock_held;
    logic [2:0]                       r_sensor_select;
    logic                             r_sensor_enable;

    cbm_pkg::t_route                  n_route;
    logic [cbm_pkg::PHYS_W-1:0]       n_phys;
    logic [cbm_pkg::DATA_W-1:0]       n_out_data;
    logic                             n_force_high;
    logic [7:0]                       n_rom_bank_low;
    logic                             n_rom_bank_ninth;
    logic [7:0]                       n_ram_bank_select;
    logic                             n_ram_enable;
    logic                             n_banking_mode;
    logic [7:0]                       n_clock_live [cbm_pkg::CLOCK_REGS];
    logic [7:0]                       n_clock_snapshot [cbm_pkg::CLOCK_REGS];
    logic                             n_clock_held;
    logic [2:0]                       n_sensor_select;
    logic                             n_sensor_enable;

    logic                             w_advance;
    logic                             w_fire;
    cbm_pkg::t_kind                   w_kind;
    logic [cbm_pkg::ROM_BANKS_W-1:0]  w_rom_limit;
    logic [cbm_pkg::RAM_BYTES_W-1:0]  w_ram_limit;
    logic [8:0]                       w_rom_bank;
    logic                             w_rom_hit;
    logic [cbm_pkg::PHYS_W-1:0]       w_rom_phys;
    logic [20:0]                      w_ram_phys;
    logic                             w_ram_hit;
    logic                             w_in_ram;
    logic [1:0]                       w_region;
    logic                             w_enable_key;
    logic                             w_clock_sel;
    logic [2:0]                       w_clock_idx;
    logic [7:0]                       w_clock_read;
    logic [4:0]                       w_bank5;
    logic [6:0]                       w_bank7;
    logic [3:0]                       w_bank4;
    logic [5:0]                       w_tick_sec;
    logic [5:0]                       w_tick_min;
    logic [4:0]                       w_tick_hour;
    logic [9:0]                       w_tick_day;

    assign w_advance = !r_out_valid || o_result.ready;
    assign w_fire    = r_in_valid && w_advance;
    assign i_item.ready = !r_in_valid || w_advance;

    assign w_kind = (r_mapper_kind > cbm_pkg::KIND_W'(cbm_pkg::KIND_SENSOR)) ?
                    cbm_pkg::KIND_FIVE_BIT : cbm_pkg::t_kind'(r_mapper_kind);
    assign w_rom_limit = (r_rom_banks > ROM_CAP) ? ROM_CAP : r_rom_banks;
    assign w_ram_limit = (r_ram_bytes > RAM_CAP) ? RAM_CAP : r_ram_bytes;

    assign w_rom_bank = (w_kind == cbm_pkg::KIND_ROM_ONLY || !r_in_addr[14]) ?
                        {8'd0, r_in_addr[14]} :
                        {(w_kind == cbm_pkg::KIND_WIDE_BANK) && r_rom_bank_ninth,
                         r_rom_bank_low};
    assign w_rom_hit  = {1'b0, w_rom_bank} < w_rom_limit;
    assign w_rom_phys = {w_rom_bank, r_in_addr[13:0]};

    assign w_ram_phys = (w_kind == cbm_pkg::KIND_ROM_ONLY) ? {8'd0, r_in_addr[12:0]} :
                        {r_ram_bank_select, r_in_addr[12:0]};
    assign w_ram_hit  = w_ram_phys < {2'b00, w_ram_limit};
    assign w_in_ram   = r_in_addr[15:13] == 3'b101;
    assign w_region   = r_in_addr[14:13];

    assign w_enable_key = r_in_data[3:0] == cbm_pkg::RAM_ENABLE_KEY;
    assign w_clock_sel  = r_ram_bank_select >= 8'd8 && r_ram_bank_select <= 8'd12;
    assign w_clock_idx  = r_ram_bank_select[2:0];
    assign w_clock_read = r_clock_held ? r_clock_snapshot[w_clock_idx] :
                          r_clock_live[w_clock_idx];

    assign w_bank5 = (r_in_data[4:0] == 5'd0) ? 5'd1 : r_in_data[4:0];
    assign w_bank7 = (r_in_data[6:0] == 7'd0) ? 7'd1 : r_in_data[6:0];
    assign w_bank4 = (r_in_data[3:0] == 4'd0) ? 4'd1 : r_in_data[3:0];

    assign w_tick_sec  = r_clock_live[0][5:0] + 6'd1;
    assign w_tick_min  = r_clock_live[1][5:0] + 6'd1;
    assign w_tick_hour = r_clock_live[2][4:0] + 5'd1;
    assign w_tick_day  = {1'b0, r_clock_live[4][0], r_clock_live[3]} + 10'd1;

    always_comb begin
        n_route           = cbm_pkg::ROUTE_NONE;
        n_phys            = '0;
        n_out_data        = '0;
        n_force_high      = 1'b0;
        n_rom_bank_low    = r_rom_bank_low;
        n_rom_bank_ninth  = r_rom_bank_ninth;
        n_ram_bank_select = r_ram_bank_select;
        n_ram_enable      = r_ram_enable;
        n_banking_mode    = r_banking_mode;
        n_clock_live      = r_clock_live;
        n_clock_snapshot  = r_clock_snapshot;
        n_clock_held      = r_clock_held;
        n_sensor_select   = r_sensor_select;
        n_sensor_enable   = r_sensor_enable;

        case (cbm_pkg::t_cmd'(r_in_cmd))
            cbm_pkg::CMD_READ: begin
                n_route = cbm_pkg::ROUTE_OPEN_BUS;
                if (!r_in_addr[15]) begin
                    if (w_rom_hit) begin
                        n_route = cbm_pkg::ROUTE_ROM_READ;
                        n_phys  = w_rom_phys;
                    end
                end else if (w_in_ram) begin
                    if (w_kind == cbm_pkg::KIND_ROM_ONLY) begin
                        if (w_ram_hit) begin
                            n_route = cbm_pkg::ROUTE_RAM_READ;
                            n_phys  = {2'b00, w_ram_phys};
                        end
                    end else if (r_ram_enable) begin
                        case (w_kind)
                            cbm_pkg::KIND_NIBBLE_RAM: begin
                                n_route      = cbm_pkg::ROUTE_RAM_READ;
                                n_phys       = {14'd0, r_in_addr[8:0]};
                                n_force_high = 1'b1;
                            end
                            cbm_pkg::KIND_CLOCK: begin
                                if (r_ram_bank_select <= 8'd3) begin
                                    if (w_ram_hit) begin
                                        n_route = cbm_pkg::ROUTE_RAM_READ;
                                        n_phys  = {2'b00, w_ram_phys};
                                    end
                                end else if (w_clock_sel) begin
                                    n_route    = cbm_pkg::ROUTE_REG_DATA;
                                    n_out_data = w_clock_read;
                                end
                            end
                            cbm_pkg::KIND_SENSOR: begin
                                if (r_ram_bank_select <= 8'd15) begin
                                    if (w_ram_hit) begin
                                        n_route = cbm_pkg::ROUTE_RAM_READ;
                                        n_phys  = {2'b00, w_ram_phys};
                                    end
                                end else if (r_ram_bank_select == cbm_pkg::SENSOR_BANK) begin
                                    n_route = cbm_pkg::ROUTE_REG_DATA;
                                end
                            end
                            default: begin
                                if (w_ram_hit) begin
                                    n_route = cbm_pkg::ROUTE_RAM_READ;
                                    n_phys  = {2'b00, w_ram_phys};
                                end
                            end
                        endcase
                    end
                end
            end
            cbm_pkg::CMD_WRITE: begin
                if (!r_in_addr[15]) begin
                    case (w_kind)
                        cbm_pkg::KIND_ROM_ONLY: begin
                        end
                        cbm_pkg::KIND_NIBBLE_RAM: begin
                            if (w_region == 2'd0 && !r_in_addr[8]) begin
                                n_ram_enable = w_enable_key;
                            end else if (w_region == 2'd1 && r_in_addr[8]) begin
                                n_rom_bank_low = {4'd0, w_bank4};
                            end
                        end
                        cbm_pkg::KIND_WIDE_BANK: begin
                            case (w_region)
                                2'd0: begin
                                    n_ram_enable = w_enable_key;
                                end
                                2'd1: begin
                                    if (!r_in_addr[12]) begin
                                        n_rom_bank_low = r_in_data;
                                    end else begin
                                        n_rom_bank_ninth = r_in_data[0];
                                    end
                                end
                                2'd2: begin
                                    n_ram_bank_select = {4'd0, r_in_data[3:0]};
                                end
                                default: begin
                                end
                            endcase
                        end
                        cbm_pkg::KIND_CLOCK, cbm_pkg::KIND_SENSOR: begin
                            case (w_region)
                                2'd0: begin
                                    n_ram_enable = w_enable_key;
                                end
                                2'd1: begin
                                    n_rom_bank_low = {1'b0, w_bank7};
                                end
                                2'd2: begin
                                    n_ram_bank_select = r_in_data;
                                    if (w_kind == cbm_pkg::KIND_SENSOR && r_in_data <= 8'd5) begin
                                        n_sensor_select = r_in_data[2:0];
                                    end
                                end
                                default: begin
                                    if (w_kind == cbm_pkg::KIND_CLOCK) begin
                                        if (r_in_data == cbm_pkg::LATCH_RELEASE) begin
                                            n_clock_held = 1'b0;
                                        end else if (r_in_data == cbm_pkg::LATCH_CAPTURE) begin
                                            n_clock_snapshot = r_clock_live;
                                            n_clock_held     = 1'b1;
                                        end
                                    end
                                end
                            endcase
                        end
                        default: begin
                            case (w_region)
                                2'd0: begin
                                    n_ram_enable = w_enable_key;
                                end
                                2'd1: begin
                                    n_rom_bank_low = {r_rom_bank_low[7:5], w_bank5};
                                end
                                2'd2: begin
                                    if (!r_banking_mode) begin
                                        n_rom_bank_low = {1'b0, r_in_data[1:0],
                                                          r_rom_bank_low[4:0]};
                                    end else begin
                                        n_ram_bank_select = {6'd0, r_in_data[1:0]};
                                    end
                                end
                                default: begin
                                    n_banking_mode = r_in_data[0];
                                end
                            endcase
                        end
                    endcase
                end else if (w_in_ram) begin
                    if (w_kind == cbm_pkg::KIND_ROM_ONLY) begin
                        if (w_ram_hit) begin
                            n_route    = cbm_pkg::ROUTE_RAM_WRITE;
                            n_phys     = {2'b00, w_ram_phys};
                            n_out_data = r_in_data;
                        end
                    end else if (r_ram_enable) begin
                        case (w_kind)
                            cbm_pkg::KIND_NIBBLE_RAM: begin
                                n_route    = cbm_pkg::ROUTE_RAM_WRITE;
                                n_phys     = {14'd0, r_in_addr[8:0]};
                                n_out_data = {4'd0, r_in_data[3:0]};
                            end
                            cbm_pkg::KIND_CLOCK: begin
                                if (r_ram_bank_select <= 8'd3) begin
                                    if (w_ram_hit) begin
                                        n_route    = cbm_pkg::ROUTE_RAM_WRITE;
                                        n_phys     = {2'b00, w_ram_phys};
                                        n_out_data = r_in_data;
                                    end
                                end else if (w_clock_sel) begin
                                    n_clock_live[w_clock_idx] =
                                        r_in_data & cbm_pkg::clock_mask(w_clock_idx);
                                end
                            end
                            cbm_pkg::KIND_SENSOR: begin
                                if (r_ram_bank_select <= 8'd15) begin
                                    if (w_ram_hit) begin
                                        n_route    = cbm_pkg::ROUTE_RAM_WRITE;
                                        n_phys     = {2'b00, w_ram_phys};
                                        n_out_data = r_in_data;
                                    end
                                end else if (r_ram_bank_select == cbm_pkg::SENSOR_BANK &&
                                             r_in_addr[12:0] == 13'd0) begin
                                    n_sensor_enable = r_in_data[0];
                                end
                            end
                            default: begin
                                if (w_ram_hit) begin
                                    n_route    = cbm_pkg::ROUTE_RAM_WRITE;
                                    n_phys     = {2'b00, w_ram_phys};
                                    n_out_data = r_in_data;
                                end
                            end
                        endcase
                    end
                end
            end
            cbm_pkg::CMD_TICK: begin
                if (!r_clock_live[4][6]) begin
                    if (w_tick_sec != 6'd60) begin
                        n_clock_live[0] = {2'b00, w_tick_sec};
                    end else begin
                        n_clock_live[0] = 8'd0;
                        if (w_tick_min != 6'd60) begin
                            n_clock_live[1] = {2'b00, w_tick_min};
                        end else begin
                            n_clock_live[1] = 8'd0;
                            if (w_tick_hour != 5'd24) begin
                                n_clock_live[2] = {3'b000, w_tick_hour};
                            end else begin
                                n_clock_live[2] = 8'd0;
                                n_clock_live[3] = w_tick_day[7:0];
                                n_clock_live[4] = {r_clock_live[4][7] | w_tick_day[9],
                                                   r_clock_live[4][6:1], w_tick_day[8]};
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper_kind <= '0;
            r_rom_banks   <= cbm_pkg::ROM_BANKS_W'(2);
            r_ram_bytes   <= '0;
        end else if (i_cfg_we) begin
            case (cbm_pkg::t_cfg_index'(i_cfg_index))
                cbm_pkg::CFG_MAPPER_KIND: begin
                    r_mapper_kind <= i_cfg_data[cbm_pkg::KIND_W-1:0];
                end
                cbm_pkg::CFG_ROM_BANKS: begin
                    r_rom_banks <= i_cfg_data[cbm_pkg::ROM_BANKS_W-1:0];
                end
                cbm_pkg::CFG_RAM_BYTES: begin
                    r_ram_bytes <= i_cfg_data[cbm_pkg::RAM_BYTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_cmd  <= i_item.cmd;
            r_in_addr <= i_item.bus_address;
            r_in_data <= i_item.bus_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_route      <= n_route;
            r_out_phys       <= n_phys;
            r_out_data       <= n_out_data;
            r_out_force_high <= n_force_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank_low    <= 8'd1;
            r_rom_bank_ninth  <= 1'b0;
            r_ram_bank_select <= 8'd0;
            r_ram_enable      <= 1'b0;
            r_banking_mode    <= 1'b0;
            r_clock_live      <= '{default: 8'd0};
            r_clock_snapshot  <= '{default: 8'd0};
            r_clock_held      <= 1'b0;
            r_sensor_select   <= 3'd0;
            r_sensor_enable   <= 1'b0;
        end else if (w_fire) begin
            r_rom_bank_low    <= n_rom_bank_low;
            r_rom_bank_ninth  <= n_rom_bank_ninth;
            r_ram_bank_select <= n_ram_bank_select;
            r_ram_enable      <= n_ram_enable;
            r_banking_mode    <= n_banking_mode;
            r_clock_live      <= n_clock_live;
            r_clock_snapshot  <= n_clock_snapshot;
            r_clock_held      <= n_clock_held;
            r_sensor_select   <= n_sensor_select;
            r_sensor_enable   <= n_sensor_enable;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.route             = r_out_route;
    assign o_result.phys_address      = r_out_phys;
    assign o_result.out_data          = r_out_data;
    assign o_result.force_high_nibble = r_out_force_high;

    a_fire_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_result.valid)
        else $error("processed item did not reach the result register");

    a_empty_result_takes_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_item.ready)
        else $error("input stalled while the result register is empty");

    a_open_bus_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.route == cbm_pkg::ROUTE_OPEN_BUS) |->
        (o_result.phys_address == '0 && o_result.out_data == '0 &&
         !o_result.force_high_nibble))
        else $error("open bus result carries address or data");

    a_ram_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && w_kind != cbm_pkg::KIND_ROM_ONLY &&
         (o_result.route == cbm_pkg::ROUTE_RAM_READ ||
          o_result.route == cbm_pkg::ROUTE_RAM_WRITE)) |-> r_ram_enable)
        else $error("RAM transfer routed while RAM is disabled");

endmodule
